>>> sv/vmtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtm_pkg
// shared types, codes and reset values of the video mode table matcher
// ----------------------------------------------------------------------------
package vmtm_pkg;

	localparam int unsigned TABLE_DEPTH_DEF     = 64;
	localparam int unsigned CANDIDATE_LIMIT_DEF = 128;

	// register reset values
	localparam logic [19:0] LINK_SPLIT_RST = 20'd165000;
	localparam logic [15:0] VERT_WIN_RST   = 16'h100;
	localparam logic [15:0] HORIZ_WIN_RST  = 16'h10;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_LINK_SPLIT = 2'd0;
	localparam logic [1:0] REG_VERT_WIN   = 2'd1;
	localparam logic [1:0] REG_HORIZ_WIN  = 2'd2;

	// commands
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// link modes
	localparam logic [1:0] LINK_SINGLE = 2'd0;
	localparam logic [1:0] LINK_DUAL   = 2'd1;

	// entry stereo modes
	localparam logic [1:0] STEREO_MONO = 2'd0;
	localparam logic [1:0] STEREO_ONLY = 2'd1;
	localparam logic [1:0] STEREO_BOTH = 2'd2;

	typedef enum logic [2:0] {
		STAT_DONE     = 3'd0,
		STAT_MATCH    = 3'd1,
		STAT_NO_VIDEO = 3'd2,
		STAT_NO_MATCH = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} fsm_state_t;

	// one table entry as stored in the entry memory
	typedef struct packed {
		logic [15:0] hsync;
		logic [15:0] vert;
		logic [15:0] horiz;
		logic [15:0] margin;
		logic [15:0] id;
		logic [1:0]  stereo;
		logic [19:0] pclk;
	} entry_t;

	// measured values of a lookup
	typedef struct packed {
		logic [15:0] hsync;
		logic [15:0] vert;
		logic [15:0] horiz;
		logic        stereo_seen;
		logic [1:0]  link_mode;
	} key_t;

	typedef struct packed {
		logic [19:0] link_split;
		logic [15:0] vert_win;
		logic [15:0] horiz_win;
	} cfg_t;

endpackage

>>> sv/vmtm_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtm_entry_ram
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module vmtm_entry_ram import vmtm_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/vmtm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtm_scan
// per-entry filter and window check, candidate count and best tracking
// ----------------------------------------------------------------------------
module vmtm_scan import vmtm_pkg::*; #(
	parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEF,
	parameter int unsigned CANDIDATE_LIMIT = CANDIDATE_LIMIT_DEF,
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	input  entry_t           rdata,
	input  key_t             key,
	input  cfg_t             cfg,
	output logic             busy,
	output logic             found,
	output logic [IDX_W-1:0] best_idx,
	output logic [15:0]      best_id
);

	localparam int unsigned CAND_W = $clog2(CANDIDATE_LIMIT + 1);

	// stage 1: read data present
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic        pass_link, pass_stereo;
	logic        in_vert, in_hsync, in_horiz;
	logic [15:0] dv, ds, dh;

	// stage 2: evaluated entry
	logic             v_s2;
	logic             filt_s2;
	logic             win_s2;
	logic [15:0]      dv_s2, ds_s2, dh_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [15:0]      id_s2;

	logic [CAND_W-1:0] cand_q;
	logic              found_q;
	logic [15:0]       bv_q, bs_q, bh_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [15:0]       best_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
	end

	always_comb begin
		case (key.link_mode)
			LINK_SINGLE: pass_link = (rdata.pclk <= cfg.link_split);
			LINK_DUAL:   pass_link = (rdata.pclk > cfg.link_split);
			default:     pass_link = 1'b1;
		endcase

		case (rdata.stereo)
			STEREO_MONO: pass_stereo = !key.stereo_seen;
			STEREO_ONLY: pass_stereo = key.stereo_seen;
			STEREO_BOTH: pass_stereo = 1'b1;
			default:     pass_stereo = 1'b0;
		endcase

		// half-open: e - w <= m < e + w
		in_vert = ({1'b0, rdata.vert} <= {1'b0, key.vert} + {1'b0, cfg.vert_win}) &&
		          ({1'b0, rdata.vert} + {1'b0, cfg.vert_win} > {1'b0, key.vert});
		// closed: m - margin <= e <= m + margin
		in_hsync = ({1'b0, rdata.hsync} + {1'b0, rdata.margin} >= {1'b0, key.hsync}) &&
		           ({1'b0, rdata.hsync} <= {1'b0, key.hsync} + {1'b0, rdata.margin});
		in_horiz = ({1'b0, rdata.horiz} <= {1'b0, key.horiz} + {1'b0, cfg.horiz_win}) &&
		           ({1'b0, rdata.horiz} + {1'b0, cfg.horiz_win} > {1'b0, key.horiz});

		dv = (rdata.vert > key.vert)   ? rdata.vert - key.vert   : key.vert - rdata.vert;
		ds = (rdata.hsync > key.hsync) ? rdata.hsync - key.hsync : key.hsync - rdata.hsync;
		dh = (rdata.horiz > key.horiz) ? rdata.horiz - key.horiz : key.horiz - rdata.horiz;
	end

	always_ff @(posedge clk) begin
		filt_s2 <= pass_link && pass_stereo;
		win_s2  <= in_vert && in_hsync && in_horiz;
		dv_s2   <= dv;
		ds_s2   <= ds;
		dh_s2   <= dh;
		idx_s2  <= idx_s1;
		id_s2   <= rdata.id;
	end

	// candidates beyond the limit are ignored; strict compare keeps earliest on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q  <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			cand_q  <= '0;
			found_q <= 1'b0;
		end else if (v_s2 && filt_s2 && (cand_q < CAND_W'(CANDIDATE_LIMIT))) begin
			cand_q <= cand_q + 1'b1;
			if (win_s2 && (!found_q || ({dv_s2, ds_s2, dh_s2} < {bv_q, bs_q, bh_q}))) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!start && v_s2 && filt_s2 && (cand_q < CAND_W'(CANDIDATE_LIMIT)) && win_s2 &&
		    (!found_q || ({dv_s2, ds_s2, dh_s2} < {bv_q, bs_q, bh_q}))) begin
			bv_q       <= dv_s2;
			bs_q       <= ds_s2;
			bh_q       <= dh_s2;
			best_idx_q <= idx_s2;
			best_id_q  <= id_s2;
		end
	end

	assign busy     = v_s1 || v_s2;
	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_id  = best_id_q;

endmodule

>>> sv/video_mode_table_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_mode_table_matcher_unit
// video mode table: clear, append and best-match lookup over stored entries
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_*       in         tuser: cmd; tdata: measured or entry values and flags
//  m_*       out        tuser: status; tdata: matched id, index, entry count
//  apb       in/out     link_split_clock, vert_window, horiz_window
//
//  clear, append, unknown command, lookup without both syncs and lookup on an
//  empty table go straight to the result; a lookup scans the filled entries,
//  one entry a cycle through the single read port of the entry memory
//  reset empties the table through the fill count, no clearing pass
//  a result not taken holds the block; the next transaction is taken meanwhile
//  only while the previous one is finished and waiting
// ----------------------------------------------------------------------------
module video_mode_table_matcher_unit import vmtm_pkg::*; #(
	parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEF,
	parameter int unsigned CANDIDATE_LIMIT = CANDIDATE_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// hsync_count, vert_value, horiz_value, hsync_margin, stereo_mode,
	// pixel_clock, entry_id, hsync_present, vsync_present, stereo_seen, link_mode
	input  logic [111:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// matched_id, matched_index, entry_count
	output logic [31:0]  m_tdata,
	// status
	output logic [2:0]   m_tuser,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	// configuration registers
	cfg_t cfg_q;

	// control
	fsm_state_t       state_q, state_d;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] rd_addr_q;
	key_t             key_q;

	// pending result
	status_t          res_status_q;
	logic [15:0]      res_id_q;
	logic [IDX_W-1:0] res_idx_q;

	// output register
	logic        m_tvalid_q;
	status_t     m_status_q;
	logic [15:0] m_id_q;
	logic [5:0]  m_idx_q;
	logic [6:0]  m_cnt_q;

	// input unpacking
	logic   in_acc;
	logic   hsp, vsp;
	entry_t in_entry;
	key_t   in_key;
	logic   tbl_full;
	logic   ram_we;

	// scan side
	logic             scan_start, rd_en, scan_last, out_load;
	entry_t           rdata;
	logic             scan_busy, scan_found;
	logic [IDX_W-1:0] scan_idx;
	logic [15:0]      scan_id;

	// ---------------------------------------------------------------- apb
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_split <= LINK_SPLIT_RST;
			cfg_q.vert_win   <= VERT_WIN_RST;
			cfg_q.horiz_win  <= HORIZ_WIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_LINK_SPLIT: cfg_q.link_split <= pwdata[19:0];
				REG_VERT_WIN:   cfg_q.vert_win   <= pwdata[15:0];
				REG_HORIZ_WIN:  cfg_q.horiz_win  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LINK_SPLIT: prdata = {12'd0, cfg_q.link_split};
			REG_VERT_WIN:   prdata = {16'd0, cfg_q.vert_win};
			REG_HORIZ_WIN:  prdata = {16'd0, cfg_q.horiz_win};
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- input
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign in_entry.hsync  = s_tdata[15:0];
	assign in_entry.vert   = s_tdata[31:16];
	assign in_entry.horiz  = s_tdata[47:32];
	assign in_entry.margin = s_tdata[63:48];
	assign in_entry.stereo = s_tdata[65:64];
	assign in_entry.pclk   = s_tdata[85:66];
	assign in_entry.id     = s_tdata[101:86];
	assign hsp             = s_tdata[102];
	assign vsp             = s_tdata[103];

	assign in_key.hsync       = s_tdata[15:0];
	assign in_key.vert        = s_tdata[31:16];
	assign in_key.horiz       = s_tdata[47:32];
	assign in_key.stereo_seen = s_tdata[104];
	assign in_key.link_mode   = s_tdata[106:105];

	assign tbl_full = (fill_q >= CNT_W'(TABLE_DEPTH));
	assign ram_we   = in_acc && (s_tuser == CMD_APPEND) && !tbl_full;

	// ---------------------------------------------------------------- fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign scan_last = ((CNT_W'(rd_addr_q) + 1'b1) == fill_q);

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if ((s_tuser == CMD_LOOKUP) && hsp && vsp && (fill_q != '0)) begin
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last entry has left the compare stages
				if (!scan_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc && (s_tuser == CMD_CLEAR)) begin
			fill_q <= '0;
		end else if (ram_we) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= in_key;
		end
		if (scan_start) begin
			rd_addr_q <= '0;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
	end

	// result of the transaction in hand
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_id_q  <= '0;
			res_idx_q <= '0;
			case (s_tuser)
				CMD_CLEAR:  res_status_q <= STAT_DONE;
				CMD_APPEND: res_status_q <= tbl_full ? STAT_FULL : STAT_DONE;
				CMD_LOOKUP: res_status_q <= (hsp && vsp) ? STAT_NO_MATCH : STAT_NO_VIDEO;
				default:    res_status_q <= STAT_DONE;
			endcase
		end else if ((state_q == ST_DRAIN) && !scan_busy) begin
			res_status_q <= scan_found ? STAT_MATCH : STAT_NO_MATCH;
			res_id_q     <= scan_found ? scan_id : '0;
			res_idx_q    <= scan_found ? scan_idx : '0;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= res_status_q;
			m_id_q     <= res_id_q;
			m_idx_q    <= 6'(res_idx_q);
			m_cnt_q    <= 7'(fill_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {3'd0, m_cnt_q, m_idx_q, m_id_q};

	// ---------------------------------------------------------------- entry memory
	// writes happen only in idle and reads only in scan, so no forwarding
	vmtm_entry_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[IDX_W-1:0]),
		.wdata(in_entry),
		.re   (rd_en),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	vmtm_scan #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.CANDIDATE_LIMIT(CANDIDATE_LIMIT)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.rd_en   (rd_en),
		.rd_idx  (rd_addr_q),
		.rdata   (rdata),
		.key     (key_q),
		.cfg     (cfg_q),
		.busy    (scan_busy),
		.found   (scan_found),
		.best_idx(scan_idx),
		.best_id (scan_id)
	);

endmodule
